@@ sv/vfcb_pkg.sv @@
`default_nettype none

package vfcb_pkg;

    // Fraction precision of the blend factor (unsigned Q1.FRAC_BITS).
    localparam int FRAC_BITS = 16;

    // Decoupling queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN      = 2'd3;

    // Plane codes.
    localparam logic [1:0] PLANE_LUMA = 2'd0;
    localparam logic [1:0] PLANE_CR   = 2'd1;
    localparam logic [1:0] PLANE_CB   = 2'd2;
    localparam logic [1:0] PLANE_NONE = 2'd3;

    typedef struct packed {
        logic [31:0] frame_time_ms;
        logic        limited_range;
        logic [1:0]  plane;
        logic [7:0]  sample;
        logic        last_in_frame;
    } vfcb_pix_t;

    typedef struct packed {
        logic [7:0] sample_out;
        logic       last_out;
    } vfcb_res_t;

    // One classified item handed from the front part to the back part.
    typedef struct packed {
        logic [31:0] elapsed;
        logic [31:0] span;
        logic        pass;
        logic [7:0]  color;
        logic [7:0]  sample;
        logic        last;
    } vfcb_job_t;

endpackage

`default_nettype wire

@@ sv/vfcb_front.sv @@
`default_nettype none

module vfcb_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pix_valid,
    output logic                        pix_stall,
    input  wire vfcb_pkg::vfcb_pix_t    pix,
    input  wire logic [31:0]            window_start_ms,
    input  wire logic [31:0]            window_end_ms,
    input  wire logic [23:0]            fill_color_rgb,
    input  wire logic [vfcb_pkg::QCW-1:0] q_count,
    output logic                        push,
    output vfcb_pkg::vfcb_job_t         job
);
    import vfcb_pkg::*;

    // Division by 1000 as multiplication by a reciprocal; exact for inputs below 2^18.
    localparam logic [18:0] RECIP  = 19'd268436;
    localparam int          RSHIFT = 28;

    logic [31:0] lo, hi, span;

    logic               a_valid_reg;
    logic [31:0]        a_elapsed_reg;
    logic [31:0]        a_span_reg;
    logic               a_pass_reg;
    logic               a_limited_reg;
    logic [1:0]         a_plane_reg;
    logic signed [19:0] a_sum_reg;
    logic [7:0]         a_sample_reg;
    logic               a_last_reg;

    logic               b_valid_reg;
    vfcb_job_t          b_job_reg;

    logic               accept;
    logic [QCW:0]       occupancy;
    logic [31:0]        t;
    logic               pass_next;
    logic signed [19:0] kr, kg, kb, rr, gg, bb, sum_next;

    logic               neg;
    logic [19:0]        mag;
    logic [17:0]        x;
    logic [36:0]        prod;
    logic signed [10:0] v, vmin, vmax;
    logic [7:0]         color_next;

    // Window bounds, ordered so that lo never exceeds hi.
    assign lo   = (window_start_ms > window_end_ms) ? window_end_ms : window_start_ms;
    assign hi   = (window_start_ms > window_end_ms) ? window_start_ms : window_end_ms;
    assign span = hi - lo;

    // Credit check: queue entries plus items in flight here never exceed the depth.
    assign occupancy = {1'b0, q_count} + (QCW+1)'(a_valid_reg) + (QCW+1)'(b_valid_reg);
    assign pix_stall = (occupancy >= (QCW+1)'(QDEPTH));
    assign accept    = pix_valid && !pix_stall;

    assign t = pix.frame_time_ms;

    always_comb
    begin
        pass_next = (lo == hi) || (t < lo) || (t > hi) ||
                    (pix.plane == PLANE_NONE);
        rr = {12'd0, fill_color_rgb[23:16]};
        gg = {12'd0, fill_color_rgb[15:8]};
        bb = {12'd0, fill_color_rgb[7:0]};
        kr = '0;
        kg = '0;
        kb = '0;
        if (pix.limited_range) begin
            unique case (pix.plane)
                PLANE_LUMA: begin kr = 20'sd257;  kg = 20'sd504;  kb = 20'sd98;  end
                PLANE_CR:   begin kr = 20'sd439;  kg = -20'sd368; kb = -20'sd71; end
                default:    begin kr = -20'sd148; kg = -20'sd291; kb = 20'sd439; end
            endcase
        end else begin
            unique case (pix.plane)
                PLANE_LUMA: begin kr = 20'sd299;  kg = 20'sd587;  kb = 20'sd114; end
                PLANE_CR:   begin kr = 20'sd500;  kg = -20'sd419; kb = -20'sd81; end
                default:    begin kr = -20'sd169; kg = -20'sd331; kb = 20'sd500; end
            endcase
        end
        sum_next = kr * rr + kg * gg + kb * bb;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            a_elapsed_reg <= t - lo;
            a_span_reg    <= span;
            a_pass_reg    <= pass_next;
            a_limited_reg <= pix.limited_range;
            a_plane_reg   <= pix.plane;
            a_sum_reg     <= sum_next;
            a_sample_reg  <= pix.sample;
            a_last_reg    <= pix.last_in_frame;
        end
    end

    // Rounded division by 1000 (half away from zero), offset and clamp.
    always_comb
    begin
        neg  = a_sum_reg[19];
        mag  = neg ? 20'(-a_sum_reg) : 20'(a_sum_reg);
        x    = mag[17:0] + 18'd500;
        prod = 37'(x) * 37'(RECIP);
        v    = neg ? -11'(prod[RSHIFT+7:RSHIFT]) : 11'(prod[RSHIFT+7:RSHIFT]);
        if (a_limited_reg) begin
            vmin = 11'sd16;
            if (a_plane_reg == PLANE_LUMA) begin
                v    = v + 11'sd16;
                vmax = 11'sd235;
            end else begin
                v    = v + 11'sd128;
                vmax = 11'sd240;
            end
        end else begin
            vmin = 11'sd0;
            vmax = 11'sd255;
            if (a_plane_reg != PLANE_LUMA) begin
                v = v + 11'sd128;
            end
        end
        if (v < vmin) begin
            color_next = vmin[7:0];
        end else if (v > vmax) begin
            color_next = vmax[7:0];
        end else begin
            color_next = v[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (a_valid_reg) begin
            b_job_reg.elapsed <= a_elapsed_reg;
            b_job_reg.span    <= a_span_reg;
            b_job_reg.pass    <= a_pass_reg;
            b_job_reg.color   <= color_next;
            b_job_reg.sample  <= a_sample_reg;
            b_job_reg.last    <= a_last_reg;
        end
    end

    assign push = b_valid_reg;
    assign job  = b_job_reg;

endmodule

`default_nettype wire

@@ sv/vfcb_queue.sv @@
`default_nettype none

module vfcb_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire vfcb_pkg::vfcb_job_t      push_job,
    input  wire logic                     pop,
    output logic                          head_valid,
    output vfcb_pkg::vfcb_job_t           head_job,
    output logic [vfcb_pkg::QCW-1:0]      count
);
    import vfcb_pkg::*;

    vfcb_job_t      mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic           do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCW'(push) - QCW'(do_pop);
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

@@ sv/vfcb_back.sv @@
`default_nettype none

module vfcb_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire vfcb_pkg::vfcb_job_t   head_job,
    output logic                       pop,
    input  wire logic                  fade_in,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output vfcb_pkg::vfcb_res_t        res
);
    import vfcb_pkg::*;

    localparam int NST = FRAC_BITS + 1;
    localparam int SH  = FRAC_BITS - 8;
    localparam int PW  = FRAC_BITS + 9;
    localparam int RW  = FRAC_BITS + 16;
    localparam logic [FRAC_BITS:0] ONE    = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [RW-1:0]      RMASK  = (RW'(1) << SH) - RW'(1);
    localparam logic [RW-1:0]      RTHR   = RW'(51) << SH;

    typedef struct packed {
        logic [31:0]        rem;
        logic [FRAC_BITS:0] quo;
        logic [31:0]        span;
        logic               pass;
        logic [7:0]         color;
        logic [7:0]         sample;
        logic               last;
    } div_t;

    logic en;
    logic d_valid_reg [NST];
    div_t d_reg       [NST];

    logic               f_valid_reg;
    logic [FRAC_BITS:0] f_g_reg;
    logic [PW-1:0]      f_p_reg;
    logic               f_pass_reg;
    logic [7:0]         f_sample_reg;
    logic               f_last_reg;

    logic               m_valid_reg;
    logic [8:0]         m_weight_reg;
    logic [15:0]        m_term_reg;
    logic               m_pass_reg;
    logic [7:0]         m_sample_reg;
    logic               m_last_reg;

    logic               o_valid_reg;
    vfcb_res_t          o_reg;

    logic [FRAC_BITS:0] f_raw, f_adj;
    logic [RW-1:0]      g_w, p_w;
    logic [8:0]         weight_next;
    logic [15:0]        term_next;
    logic [16:0]        px;

    // The whole back pipeline holds while a result waits at a stalled output.
    assign en  = !(o_valid_reg && res_stall);
    assign pop = en && head_valid;

    // Long division, one quotient bit per stage, remainder kept below the span for items that are not passed.
    always_ff @(posedge clk) begin
        if (en) begin
            d_reg[0].quo  <= (FRAC_BITS+1)'(head_job.elapsed >= head_job.span);
            d_reg[0].rem  <= (head_job.elapsed >= head_job.span) ?
                             head_job.elapsed - head_job.span : head_job.elapsed;
            d_reg[0].span   <= head_job.span;
            d_reg[0].pass   <= head_job.pass;
            d_reg[0].color  <= head_job.color;
            d_reg[0].sample <= head_job.sample;
            d_reg[0].last   <= head_job.last;
        end
    end

    for (genvar i = 1; i < NST; i++) begin : g_div
        logic [32:0] dbl;
        logic        bit_q;
        div_t        stage_next;
        assign dbl   = {d_reg[i-1].rem, 1'b0};
        assign bit_q = (dbl >= {1'b0, d_reg[i-1].span});
        always_comb
        begin
            stage_next     = d_reg[i-1];
            stage_next.quo = {d_reg[i-1].quo[FRAC_BITS-1:0], bit_q};
            stage_next.rem = bit_q ? 32'(dbl - {1'b0, d_reg[i-1].span}) : dbl[31:0];
        end
        always_ff @(posedge clk) begin
            if (en) begin
                d_reg[i] <= stage_next;
            end
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_dv
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                d_valid_reg[i] <= 1'b0;
            end else if (en) begin
                d_valid_reg[i] <= (i == 0) ? head_valid : d_valid_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // Fraction, its complement and the colour product.
    always_comb
    begin
        f_raw = d_reg[NST-1].quo;
        f_adj = (f_raw > ONE) ? ONE : f_raw;
        if (fade_in) begin
            f_adj = ONE - f_adj;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= d_valid_reg[NST-1];
            m_valid_reg <= f_valid_reg;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            f_g_reg      <= ONE - f_adj;
            f_p_reg      <= PW'(d_reg[NST-1].color) * PW'(f_adj);
            f_pass_reg   <= d_reg[NST-1].pass;
            f_sample_reg <= d_reg[NST-1].sample;
            f_last_reg   <= d_reg[NST-1].last;
        end
    end

    // floor(v / 2^SH + 0.49): round up when the dropped part is at least 0.51.
    always_comb
    begin
        g_w = RW'(f_g_reg);
        p_w = RW'(f_p_reg);
        weight_next = 9'(g_w >> SH) + 9'(((g_w & RMASK) * RW'(100)) >= RTHR);
        term_next   = 16'(p_w >> SH) + 16'(((p_w & RMASK) * RW'(100)) >= RTHR);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            m_weight_reg <= weight_next;
            m_term_reg   <= term_next;
            m_pass_reg   <= f_pass_reg;
            m_sample_reg <= f_sample_reg;
            m_last_reg   <= f_last_reg;
        end
    end

    assign px = (17'(m_weight_reg) * 17'(m_sample_reg) + 17'(m_term_reg)) >> 8;

    always_ff @(posedge clk) begin
        if (en) begin
            if (m_pass_reg) begin
                o_reg.sample_out <= m_sample_reg;
            end else begin
                o_reg.sample_out <= (px > 17'd255) ? 8'd255 : px[7:0];
            end
            o_reg.last_out <= m_last_reg;
        end
    end

    assign res_valid = o_valid_reg;
    assign res       = o_reg;

endmodule

`default_nettype wire

@@ sv/video_fade_to_color_blend.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// pix       in         pix_valid / pix_stall  vfcb_pix_t: time, range, plane, sample, last
// res       out        res_valid / res_stall  vfcb_res_t: sample_out, last_out
// cfg       in         cfg_we                 cfg_index selects the register, cfg_data holds it
//
// One sample is taken per clock and one result leaves per clock in steady flow.
// The path runs through two front stages, the queue, FRAC_BITS + 1
// divider stages (one quotient bit each) and three blend stages including the output.
// Reset clears all control state and the configuration registers to zero.
// A stalled output freezes the back pipeline; the front keeps taking samples until
// the four-entry queue, counted with the front stages, is full.

module video_fade_to_color_blend (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pix_valid,
    output logic                                 pix_stall,
    input  wire vfcb_pkg::vfcb_pix_t             pix,
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output vfcb_pkg::vfcb_res_t                  res,
    input  wire logic                            cfg_we,
    input  wire logic [vfcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data
);
    import vfcb_pkg::*;

    // Configuration registers. The user must change them only while the block is idle; the block does not enforce it.
    logic [31:0] window_start_reg;
    logic [31:0] window_end_reg;
    logic [23:0] fill_color_reg;
    logic        fade_in_reg;

    logic           push;
    vfcb_job_t      push_job;
    logic           pop;
    logic           head_valid;
    vfcb_job_t      head_job;
    logic [QCW-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_start_reg <= '0;
            window_end_reg   <= '0;
            fill_color_reg   <= '0;
            fade_in_reg      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WINDOW_START: window_start_reg <= cfg_data;
                REG_WINDOW_END:   window_end_reg   <= cfg_data;
                REG_FILL_COLOR:   fill_color_reg   <= cfg_data[23:0];
                REG_FADE_IN:      fade_in_reg      <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // The front orders the window, checks the time against it, works out the
    // elapsed time and span, and converts the fill colour for the sample's plane.
    vfcb_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .pix_valid       (pix_valid),
        .pix_stall       (pix_stall),
        .pix             (pix),
        .window_start_ms (window_start_reg),
        .window_end_ms   (window_end_reg),
        .fill_color_rgb  (fill_color_reg),
        .q_count         (q_count),
        .push            (push),
        .job             (push_job)
    );

    // The queue decouples the front from stalls at the output.
    vfcb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (q_count)
    );

    // The back divides for the fade fraction, forms the rounded weights and
    // blends the sample with the colour term; passed samples go through as is.
    vfcb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .fade_in    (fade_in_reg),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

`default_nettype wire

@@ test/fade_blend_checker.sv @@
`default_nettype none

module fade_blend_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pix_valid,
    input  wire logic                 pix_stall,
    input  wire vfcb_pkg::vfcb_pix_t  pix,
    input  wire logic                 res_valid,
    input  wire logic                 res_stall,
    input  wire vfcb_pkg::vfcb_res_t  res,
    input  wire logic                 cfg_we,
    input  wire logic [vfcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output int                        fail_count,
    output int                        pending_count,
    output int                        blended_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vfcb_pkg::*;

    logic [31:0] win_a, win_b;
    logic [23:0] fill_rgb;
    logic        fade_in_mode;
    vfcb_res_t   expected_q[$];

    function automatic longint round_thousandths(longint s);
        if (s >= 0)
            return (s + 500) / 1000;
        return -((-s + 500) / 1000);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Fill color in the plane's color space.
    function automatic longint fill_level(logic [1:0] plane, logic limited);
        longint r, g, b;
        r = fill_rgb[23:16];
        g = fill_rgb[15:8];
        b = fill_rgb[7:0];
        if (limited) begin
            if (plane == PLANE_LUMA)
                return clip(round_thousandths(257*r + 504*g + 98*b) + 16, 16, 235);
            if (plane == PLANE_CR)
                return clip(round_thousandths(439*r - 368*g - 71*b) + 128, 16, 240);
            return clip(round_thousandths(-148*r - 291*g + 439*b) + 128, 16, 240);
        end
        if (plane == PLANE_LUMA)
            return clip(round_thousandths(299*r + 587*g + 114*b), 0, 255);
        if (plane == PLANE_CR)
            return clip(round_thousandths(500*r - 419*g - 81*b) + 128, 0, 255);
        return clip(round_thousandths(-169*r - 331*g + 500*b) + 128, 0, 255);
    endfunction

    function automatic vfcb_res_t blend_sample(vfcb_pix_t p, output bit blended);
        vfcb_res_t   o;
        logic [31:0] lo, hi;
        longint unsigned unit_f, frac, wgt, term, px, elapsed, span, den, c;
        lo = (win_a > win_b) ? win_b : win_a;
        hi = (win_a > win_b) ? win_a : win_b;
        o.sample_out = p.sample;
        o.last_out = p.last_in_frame;
        blended = 0;
        if (lo != hi && p.frame_time_ms >= lo && p.frame_time_ms <= hi
                && p.plane != PLANE_NONE) begin
            blended = 1;
            unit_f = 64'd1 << FRAC_BITS;
            elapsed = p.frame_time_ms - lo;
            span = hi - lo;
            frac = (elapsed << FRAC_BITS) / span;
            if (frac > unit_f)
                frac = unit_f;
            if (fade_in_mode)
                frac = unit_f - frac;
            den = 100 * unit_f;
            c = fill_level(p.plane, p.limited_range);
            wgt = ((unit_f - frac) * 25600 + 49 * unit_f) / den;
            term = (c * frac * 25600 + 49 * unit_f) / den;
            px = (wgt * p.sample + term) >> 8;
            o.sample_out = (px > 255) ? 8'd255 : px[7:0];
        end
        return o;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge clk or negedge rst_n) begin
        vfcb_res_t exp_r;
        bit        hit;
        int        errs;
        if (!rst_n) begin
            win_a <= '0;
            win_b <= '0;
            fill_rgb <= '0;
            fade_in_mode <= 1'b0;
            fail_count <= 0;
            blended_count <= 0;
            expected_q.delete();
        end else begin
            errs = 0;
            if (res_valid && !res_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result %h", res);
                    errs++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (res.sample_out !== exp_r.sample_out) begin
                        $error("sample_out: expected %0d, got %0d",
                               exp_r.sample_out, res.sample_out);
                        errs++;
                    end
                    if (res.last_out !== exp_r.last_out) begin
                        $error("last_out: expected %0d, got %0d",
                               exp_r.last_out, res.last_out);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (pix_valid && !pix_stall) begin
                expected_q.push_back(blend_sample(pix, hit));
                if (hit)
                    blended_count <= blended_count + 1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_WINDOW_START: win_a <= cfg_data;
                    REG_WINDOW_END:   win_b <= cfg_data;
                    REG_FILL_COLOR:   fill_rgb <= cfg_data[23:0];
                    REG_FADE_IN:      fade_in_mode <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none

// Stimulus and verdict for the fade blend. The checker beside the block
// predicts every result and counts mismatches; this module only drives
// transfers, writes the registers between phases and decides the outcome.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vfcb_pkg::*;

    localparam int LATENCY = FRAC_BITS + 7;
    localparam int HOLDOFF_LEN = 200;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_stall;
    vfcb_pix_t pix = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    vfcb_res_t res;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_START;
    logic [31:0] cfg_data = '0;

    int fail_count, pending_count, blended_count;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int holdoff_cycles = 0;
    bit holdoff_go = 1'b0;
    bit holdoff_started = 1'b0;
    longint cycle_count = 0;
    int sent_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    video_fade_to_color_blend dut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fade_blend_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .blended_count(blended_count)
    );

    // The timeout guard; it ends the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // The receiver stalls at random, or holds off solidly for a long stretch
    // once asked to, so that the queue fills and the input stalls.
    always @(negedge clk)
    begin
        if (holdoff_go && !holdoff_started) begin
            holdoff_started <= 1'b1;
            holdoff_cycles <= HOLDOFF_LEN - 1;
            res_stall <= 1'b1;
        end else if (holdoff_cycles > 0) begin
            res_stall <= 1'b1;
            holdoff_cycles <= holdoff_cycles - 1;
        end else begin
            res_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stops offering samples, waits until every predicted result has come back,
    // and then lets the clock run on before returning.
    task automatic drain;
        pix_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_window(input logic [31:0] a, input logic [31:0] b,
                              input logic [23:0] rgb, input logic fade);
        drain();
        write_reg(REG_WINDOW_START, a);
        write_reg(REG_WINDOW_END, b);
        write_reg(REG_FILL_COLOR, {8'd0, rgb});
        write_reg(REG_FADE_IN, {31'd0, fade});
    endtask

    // Offers one sample, with an optional idle gap first, and holds it
    // until the block takes it. Valid stays high between back-to-back transfers;
    // the stall seen at a falling edge holds until the next rising edge.
    task automatic send_sample(input vfcb_pix_t p);
        while ($urandom_range(99) < sender_idle_pct) begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix <= p;
        while (pix_stall)
            @(negedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    function automatic vfcb_pix_t make_sample(input logic [31:0] t);
        vfcb_pix_t p;
        p.frame_time_ms = t;
        p.limited_range = 1'($urandom_range(1));
        p.plane = ($urandom_range(19) == 0) ? PLANE_NONE : 2'($urandom_range(2));
        p.sample = 8'($urandom_range(255));
        p.last_in_frame = ($urandom_range(7) == 0);
        return p;
    endfunction

    // A frame time mostly inside the window, sometimes on its bounds or outside.
    function automatic logic [31:0] pick_time(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] lo, hi;
        lo = (a > b) ? b : a;
        hi = (a > b) ? a : b;
        case ($urandom_range(9))
            0: return lo;
            1: return hi;
            2: return $urandom();
            3: return (lo == 0) ? 32'd0 : lo - 1;
            4: return (hi == 32'hFFFF_FFFF) ? hi : hi + 1;
            default: return lo + 32'(64'($urandom()) % (64'(hi - lo) + 1));
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] a, b;
        case ($urandom_range(3))
            0: begin a = $urandom_range(5000); b = a + $urandom_range(3000); end
            1: begin b = $urandom_range(5000); a = b + $urandom_range(1, 3000); end
            2: begin a = $urandom(); b = $urandom(); end
            default: begin a = $urandom_range(100); b = a + $urandom_range(1, 3); end
        endcase
        set_window(a, b, 24'($urandom()), 1'($urandom_range(1)));
        repeat (count)
            send_sample(make_sample(pick_time(a, b)));
    endtask

    initial
    begin
        vfcb_pix_t p;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset state has equal bounds, so samples pass through.
        p = '{frame_time_ms: 0, limited_range: 1'b0, plane: PLANE_LUMA,
              sample: 8'hFF, last_in_frame: 1'b1};
        send_sample(p);

        // Reversed bounds, white fill, fade to the color across the extremes.
        set_window(32'd1000, 32'd0, 24'hFFFFFF, 1'b0);
        for (int i = 0; i < 4; i++) begin
            p = '{frame_time_ms: 32'(i * 333), limited_range: i[0],
                  plane: 2'(i), sample: (i[1] ? 8'h00 : 8'hFF),
                  last_in_frame: i[0]};
            send_sample(p);
        end
        p.frame_time_ms = 1000; p.plane = PLANE_CB; send_sample(p);
        p.frame_time_ms = 1001; send_sample(p);

        // Full-width window, saturated colors and fade-in.
        set_window(32'd0, 32'hFFFF_FFFF, 24'hFF0000, 1'b1);
        for (int i = 0; i < 6; i++) begin
            p = '{frame_time_ms: (i[0] ? 32'hFFFF_FFFF : 32'h8000_0000 >> i),
                  limited_range: i[1], plane: 2'(i % 3), sample: 8'(i * 51),
                  last_in_frame: i[2]};
            send_sample(p);
        end
        set_window(32'd7, 32'd8, 24'h0000FF, 1'b0);
        for (int i = 0; i < 6; i++) begin
            p = '{frame_time_ms: 32'(6 + i % 3), limited_range: i[0],
                  plane: 2'(i % 3), sample: 8'h80, last_in_frame: 1'b0};
            send_sample(p);
        end

        // Random phases under the three idling profiles.
        sender_idle_pct = 35;
        receiver_idle_pct = 52;
        repeat (6) random_phase(50);
        sender_idle_pct = 52;
        receiver_idle_pct = 35;
        repeat (6) random_phase(50);

        // Long hold-off while the sender keeps offering samples.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        set_window(32'd0, 32'd4000, 24'h40C020, 1'b0);
        holdoff_go = 1'b1;
        repeat (50) send_sample(make_sample(pick_time(32'd0, 32'd4000)));
        repeat (6) random_phase(50);

        drain();
        $display("sent %0d samples, %0d blended inside a fade window",
                 sent_count, blended_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire

@@ files.f @@
sv/vfcb_pkg.sv
sv/vfcb_front.sv
sv/vfcb_queue.sv
sv/vfcb_back.sv
sv/video_fade_to_color_blend.sv
test/fade_blend_checker.sv
test/testbench.sv
